@@ design/burh_pkg.sv @@
// Shared types and constants for the bounded undo/redo history.
`default_nettype none

package burh_pkg;

   localparam int DEPTH_DEF        = 16;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int WORD_BITS        = 32;
   localparam int OPCODE_BITS      = 2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_PUSH  = 2'd0,
      OP_UNDO  = 2'd1,
      OP_REDO  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   // Shift controls for the cell row; "deeper" moves toward higher cell index.
   typedef struct packed {
      logic undo_deeper;
      logic undo_shallower;
      logic redo_deeper;
      logic redo_shallower;
   } shift_ctl_type;

endpackage

`default_nettype wire

@@ design/bounded_undo_redo_history.sv @@
// Bounded undo/redo history built as two stacks in a row of shifting cells.
// An accepted request's result is in the output register in the next cycle.
// Throughput: one request per cycle unless stalled; each shifts the cell row at most one place.
// A request is taken whenever the output register is empty or being drained.
// Reset clears the cursor, the entry count and the output valid, and sets numbering to 1.
// Cell contents are not reset; only slots below the entry count are ever returned.
`default_nettype none

module bounded_undo_redo_history #(
   parameter int DEPTH        = burh_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BITS = burh_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // push_sequence[31:0], push_payload[63:32]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [71:0] rsp_tdata,   // entry_sequence[31:0], entry_payload[63:32],
                                         // undo_available[64], redo_available[65], zero pad
   output logic             rsp_tuser    // ok[0]
);

   localparam int WORD_BITS  = burh_pkg::WORD_BITS;
   localparam int ENTRY_BITS = WORD_BITS + PAYLOAD_BITS;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic                     fire;
   burh_pkg::opcode_type     opcode;
   logic [WORD_BITS-1:0]     push_sequence;
   logic [PAYLOAD_BITS-1:0]  push_payload;

   logic [CNT_BITS-1:0]  cursor_ff, cursor_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [WORD_BITS-1:0] next_ff, next_in;
   logic [WORD_BITS-1:0] assigned_seq;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 ok_ff, ok_in;
   logic [WORD_BITS-1:0] seq_ff, seq_in;
   logic [WORD_BITS-1:0] pay_ff, pay_in;
   logic                 undo_av_ff, undo_av_in;
   logic                 redo_av_ff, redo_av_in;

   burh_pkg::shift_ctl_type ctl;
   logic [ENTRY_BITS-1:0]   undo_q [DEPTH];
   logic [ENTRY_BITS-1:0]   redo_q [DEPTH];
   logic [ENTRY_BITS-1:0]   undo_head_in;
   logic [ENTRY_BITS-1:0]   new_entry;

   assign req_tready    = !rsp_valid_ff || rsp_tready;
   assign fire          = req_tvalid && req_tready;
   assign opcode        = burh_pkg::opcode_type'(req_tuser);
   assign push_sequence = req_tdata[WORD_BITS-1:0];
   assign push_payload  = req_tdata[WORD_BITS +: PAYLOAD_BITS];

   assign assigned_seq  = (push_sequence == '0) ? next_ff : push_sequence;
   assign new_entry     = {assigned_seq, push_payload};
   assign undo_head_in  = (opcode == burh_pkg::OP_PUSH) ? new_entry : redo_q[0];

   always_comb begin
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      ctl          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ok_in        = ok_ff;
      seq_in       = seq_ff;
      pay_in       = pay_ff;
      undo_av_in   = undo_av_ff;
      redo_av_in   = redo_av_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         ok_in        = 1'b0;
         seq_in       = '0;
         pay_in       = '0;
         case (opcode)
            burh_pkg::OP_PUSH: begin
               // Drop the redo tail; the bottom cell falls off when full.
               ctl.undo_deeper = 1'b1;
               if (cursor_ff != FULL_CNT) begin
                  cursor_in = cursor_ff + CNT_BITS'(1);
               end
               count_in = (cursor_ff != FULL_CNT) ? cursor_ff + CNT_BITS'(1) : cursor_ff;
               if (push_sequence == '0) begin
                  next_in = next_ff + WORD_BITS'(1);
               end else if (next_ff <= push_sequence) begin
                  next_in = push_sequence + WORD_BITS'(1);
               end
               ok_in  = 1'b1;
               seq_in = assigned_seq;
            end
            burh_pkg::OP_UNDO: begin
               if (cursor_ff != '0) begin
                  ctl.undo_shallower = 1'b1;
                  ctl.redo_deeper    = 1'b1;
                  cursor_in = cursor_ff - CNT_BITS'(1);
                  ok_in     = 1'b1;
                  seq_in    = undo_q[0][ENTRY_BITS-1 -: WORD_BITS];
                  pay_in    = WORD_BITS'(undo_q[0][PAYLOAD_BITS-1:0]);
               end
            end
            burh_pkg::OP_REDO: begin
               if (cursor_ff < count_ff) begin
                  ctl.redo_shallower = 1'b1;
                  ctl.undo_deeper    = 1'b1;
                  cursor_in = cursor_ff + CNT_BITS'(1);
                  ok_in     = 1'b1;
                  seq_in    = redo_q[0][ENTRY_BITS-1 -: WORD_BITS];
                  pay_in    = WORD_BITS'(redo_q[0][PAYLOAD_BITS-1:0]);
               end
            end
            burh_pkg::OP_CLEAR: begin
               cursor_in = '0;
               count_in  = '0;
               next_in   = WORD_BITS'(1);
               ok_in     = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
         undo_av_in = (cursor_in != '0);
         redo_av_in = (cursor_in < count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         count_ff     <= '0;
         next_ff      <= WORD_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff      <= ok_in;
      seq_ff     <= seq_in;
      pay_ff     <= pay_in;
      undo_av_ff <= undo_av_in;
      redo_av_ff <= redo_av_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_BITS-1:0] undo_near, undo_far, redo_near, redo_far;
      if (i == 0) begin : g_head
         assign undo_near = undo_head_in;
         assign redo_near = undo_q[0];
      end else begin : g_body
         assign undo_near = undo_q[i-1];
         assign redo_near = redo_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign undo_far = undo_q[i];
         assign redo_far = redo_q[i];
      end else begin : g_link
         assign undo_far = undo_q[i+1];
         assign redo_far = redo_q[i+1];
      end
      burh_cell #(
         .ENTRY_BITS(ENTRY_BITS)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .undo_near(undo_near),
         .undo_far (undo_far),
         .redo_near(redo_near),
         .redo_far (redo_far),
         .undo_q   (undo_q[i]),
         .redo_q   (redo_q[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = {6'd0, redo_av_ff, undo_av_ff, pay_ff, seq_ff};

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond entry count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_push_result: assert property (@(posedge clock) disable iff (reset)
      fire && opcode == burh_pkg::OP_PUSH |=> rsp_tvalid && ok_ff && undo_av_ff && !redo_av_ff)
      else $error("push result not flagged as success");

   a_failed_undo: assert property (@(posedge clock) disable iff (reset)
      fire && opcode == burh_pkg::OP_UNDO && cursor_ff == '0 |=> $stable(cursor_ff) && !ok_ff)
      else $error("undo with empty history changed state");

endmodule

`default_nettype wire

@@ design/burh_cell.sv @@
// One history cell: holds one undo-stack slot and one redo-stack slot.
`default_nettype none

module burh_cell #(
   parameter int ENTRY_BITS = burh_pkg::WORD_BITS + burh_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire burh_pkg::shift_ctl_type ctl,
   input  wire logic [ENTRY_BITS-1:0]   undo_near,
   input  wire logic [ENTRY_BITS-1:0]   undo_far,
   input  wire logic [ENTRY_BITS-1:0]   redo_near,
   input  wire logic [ENTRY_BITS-1:0]   redo_far,
   output logic      [ENTRY_BITS-1:0]   undo_q,
   output logic      [ENTRY_BITS-1:0]   redo_q
);

   logic [ENTRY_BITS-1:0] undo_ff, undo_in;
   logic [ENTRY_BITS-1:0] redo_ff, redo_in;

   always_comb begin
      if (ctl.undo_deeper) begin
         undo_in = undo_near;
      end else if (ctl.undo_shallower) begin
         undo_in = undo_far;
      end else begin
         undo_in = undo_ff;
      end
      if (ctl.redo_deeper) begin
         redo_in = redo_near;
      end else if (ctl.redo_shallower) begin
         redo_in = redo_far;
      end else begin
         redo_in = redo_ff;
      end
   end

   // Entries are undefined until written, so no reset.
   always_ff @(posedge clock) begin
      undo_ff <= undo_in;
      redo_ff <= redo_in;
   end

   assign undo_q = undo_ff;
   assign redo_q = redo_ff;

endmodule

`default_nettype wire
